### src/sliding_window_mode_filter_defines.svh
// Assertion macros for the sliding window mode filter.
// SWMF_ASSERT is gated by reset; SWMF_ASSERT_RST also holds while reset is applied.
`ifndef SLIDING_WINDOW_MODE_FILTER_DEFINES_SVH
`define SLIDING_WINDOW_MODE_FILTER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define SWMF_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define SWMF_ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define SWMF_ASSERT(name, prop, msg)
`define SWMF_ASSERT_RST(name, prop, msg)
`endif

`endif

### src/swmf_pkg.sv
package swmf_pkg;

  localparam int CODE_W     = 3;
  localparam int FUNC_W     = 2;
  localparam int WSIZE_W    = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;
  localparam int NUM_CODES  = 1 << CODE_W;

  localparam logic [FUNC_W-1:0] FUNC_PUSH   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_REINIT = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_CODE  = 2'd1;

  localparam logic [WSIZE_W-1:0] WINDOW_SIZE_RST = 5'd8;
  localparam logic [CODE_W-1:0]  START_CODE_RST  = 3'd0;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [CODE_W-1:0] code;
  } in_item_t;

  typedef struct packed {
    logic [CODE_W-1:0] mode_code;
    logic              found;
  } out_item_t;

  typedef struct packed {
    logic capture;     // latch the incoming transaction
    logic do_push;     // write sample, advance pointer
    logic do_reinit;   // refill window with start code
    logic scan_start;  // rewind scan address; clears histogram in count phase
    logic scan_issue;  // read one entry
    logic mode_phase;  // 0: histogram count, 1: mode pick
    logic out_load;    // load result register
  } ctrl_cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              scan_last;
    logic              out_free;
  } ctrl_status_t;

endpackage

### src/swmf_ram.sv
module swmf_ram #(
  parameter int WIDTH = 3,
  parameter int DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### src/swmf_ctrl.sv
module swmf_ctrl import swmf_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  ctrl_status_t status_i,
  output ctrl_cmd_t    cmd_o
);

  typedef enum logic [6:0] {
    ST_IDLE      = 7'b0000001,
    ST_START     = 7'b0000010,
    ST_HIST      = 7'b0000100,
    ST_HIST_WAIT = 7'b0001000,
    ST_MODE      = 7'b0010000,
    ST_MODE_WAIT = 7'b0100000,
    ST_DONE      = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_START;
        end
      end
      ST_START: begin
        unique case (status_i.func)
          FUNC_PUSH: begin
            cmd_o.do_push    = 1'b1;
            cmd_o.scan_start = 1'b1;
            state_d          = ST_HIST;
          end
          FUNC_QUERY: begin
            cmd_o.scan_start = 1'b1;
            state_d          = ST_HIST;
          end
          FUNC_REINIT: begin
            cmd_o.do_reinit = 1'b1;
            state_d         = ST_DONE;
          end
          default: begin
            state_d = ST_DONE;
          end
        endcase
      end
      ST_HIST: begin
        cmd_o.scan_issue = 1'b1;
        if (status_i.scan_last) begin
          state_d = ST_HIST_WAIT;
        end
      end
      ST_HIST_WAIT: begin
        // last histogram read lands this cycle
        if (status_i.func == FUNC_PUSH) begin
          cmd_o.scan_start = 1'b1;
          cmd_o.mode_phase = 1'b1;
          state_d          = ST_MODE;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_MODE: begin
        cmd_o.scan_issue = 1'b1;
        cmd_o.mode_phase = 1'b1;
        if (status_i.scan_last) begin
          state_d = ST_MODE_WAIT;
        end
      end
      ST_MODE_WAIT: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

endmodule

### src/swmf_dpath.sv
module swmf_dpath import swmf_pkg::*; #(
  parameter int MAX_WINDOW = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ctrl_cmd_t          cmd_i,
  output ctrl_status_t       status_o,
  input  in_item_t           in_data_i,
  input  logic [WSIZE_W-1:0] window_size_i,
  input  logic [CODE_W-1:0]  start_code_i,
  input  logic               out_stall_i,
  output logic               out_valid_o,
  output out_item_t          out_data_o
);

  localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CNT_W = $clog2(MAX_WINDOW + 1);

  logic [FUNC_W-1:0]     func_q;
  logic [CODE_W-1:0]     code_q;
  logic [IDX_W-1:0]      ptr_q;
  logic [MAX_WINDOW-1:0] valid_q;
  logic [CODE_W-1:0]     fill_q;
  logic [CODE_W-1:0]     mode_q;
  logic [IDX_W-1:0]      addr_q;
  logic                  rd_pend_q;
  logic                  rd_mode_q;
  logic                  rd_vld_q;
  logic [CNT_W-1:0]      best_cnt_q;
  logic [CNT_W-1:0]      hist_q [NUM_CODES];
  logic                  out_valid_q;
  out_item_t             out_data_q;

  logic [CNT_W-1:0]  win_len;
  logic [IDX_W-1:0]  wr_idx;
  logic [IDX_W-1:0]  ptr_d;
  logic [CODE_W-1:0] ram_rdata;
  logic [CODE_W-1:0] rd_code;
  logic              found;

  // active length: zero acts as one, oversize saturates
  always_comb begin
    if (window_size_i == '0) begin
      win_len = CNT_W'(1);
    end else if (9'(window_size_i) > 9'(MAX_WINDOW)) begin
      win_len = CNT_W'(MAX_WINDOW);
    end else begin
      win_len = CNT_W'(window_size_i);
    end
  end

  // pointer left beyond a shrunk window restarts at entry 0
  always_comb begin
    if (CNT_W'(ptr_q) >= win_len) begin
      wr_idx = '0;
    end else begin
      wr_idx = ptr_q;
    end
    if (CNT_W'(wr_idx) + CNT_W'(1) == win_len) begin
      ptr_d = '0;
    end else begin
      ptr_d = wr_idx + IDX_W'(1);
    end
  end

  swmf_ram #(
    .WIDTH(CODE_W),
    .DEPTH(MAX_WINDOW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.do_push),
    .waddr_i(wr_idx),
    .wdata_i(code_q),
    .raddr_i(addr_q),
    .rdata_o(ram_rdata)
  );

  // entries not written since reinit hold the fill code
  assign rd_code = rd_vld_q ? ram_rdata : fill_q;
  assign found   = (func_q == FUNC_QUERY) && (hist_q[code_q] != '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q <= in_data_i.func;
      code_q <= in_data_i.code;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_start && !cmd_i.mode_phase) begin
      for (int k = 0; k < NUM_CODES; k++) begin
        hist_q[k] <= '0;
      end
    end else if (rd_pend_q && !rd_mode_q) begin
      hist_q[rd_code] <= hist_q[rd_code] + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q      <= '0;
      valid_q    <= '0;
      fill_q     <= '0;
      mode_q     <= '0;
      addr_q     <= '0;
      rd_pend_q  <= 1'b0;
      rd_mode_q  <= 1'b0;
      rd_vld_q   <= 1'b0;
      best_cnt_q <= '0;
    end else begin
      if (cmd_i.do_push) begin
        ptr_q           <= ptr_d;
        valid_q[wr_idx] <= 1'b1;
      end else if (cmd_i.do_reinit) begin
        ptr_q   <= '0;
        valid_q <= '0;
        fill_q  <= start_code_i;
      end

      if (cmd_i.scan_start) begin
        addr_q     <= '0;
        best_cnt_q <= '0;
      end else if (cmd_i.scan_issue) begin
        addr_q <= addr_q + IDX_W'(1);
      end
      rd_pend_q <= cmd_i.scan_issue;
      rd_mode_q <= cmd_i.mode_phase;
      rd_vld_q  <= valid_q[addr_q];

      // strict compare keeps the lowest index on ties
      if (cmd_i.do_reinit) begin
        mode_q <= start_code_i;
      end else if (rd_pend_q && rd_mode_q && (hist_q[rd_code] > best_cnt_q)) begin
        best_cnt_q <= hist_q[rd_code];
        mode_q     <= rd_code;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_data_q.mode_code <= mode_q;
      out_data_q.found     <= found;
    end
  end

  assign status_o.func      = func_q;
  assign status_o.scan_last = (CNT_W'(addr_q) == win_len - CNT_W'(1));
  assign status_o.out_free  = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

### src/sliding_window_mode_filter.sv
// One transaction at a time: a push scans the window entries through the single read port of
// the window RAM twice (histogram pass, then mode pass), a query once (histogram pass only);
// reinit and unused codes do not scan the window.
// Reset (async, active low) empties the window to code zero, clears pointer and mode,
// loads window_size = 8 and start_code = 0; no clearing pass is needed.
`include "sliding_window_mode_filter_defines.svh"

module sliding_window_mode_filter import swmf_pkg::*; #(
  parameter int MAX_WINDOW = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_item_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_item_t             out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  logic [WSIZE_W-1:0] window_size_q;
  logic [CODE_W-1:0]  start_code_q;
  ctrl_cmd_t          cmd;
  ctrl_status_t       status;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_size_q <= WINDOW_SIZE_RST;
      start_code_q  <= START_CODE_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_WINDOW_SIZE: window_size_q <= cfg_wdata_i[WSIZE_W-1:0];
        REG_START_CODE:  start_code_q  <= cfg_wdata_i[CODE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  swmf_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  swmf_dpath #(
    .MAX_WINDOW(MAX_WINDOW)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .in_data_i    (in_data_i),
    .window_size_i(window_size_q),
    .start_code_i (start_code_q),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .out_data_o   (out_data_o)
  );

  `SWMF_ASSERT(a_busy_after_accept, (in_valid_i && !in_stall_o) |=> in_stall_o, "not busy after accept")
  `SWMF_ASSERT(a_load_needs_room, cmd.out_load |-> status.out_free, "result overwrites pending result")
  `SWMF_ASSERT(a_valid_from_load, $rose(out_valid_o) |-> $past(cmd.out_load), "result without load")
  `SWMF_ASSERT(a_scan_while_busy, cmd.scan_issue |-> in_stall_o, "scan while accepting")
  `SWMF_ASSERT_RST(a_reset_no_result, !rst_ni |-> !out_valid_o, "result valid in reset")

endmodule

### dv/sliding_window_mode_filter_tb.sv
`timescale 1ns / 100ps

module sliding_window_mode_filter_tb import swmf_pkg::*; ();

  localparam int WINDOW_DEPTH  = 16;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 220;
  localparam int DRAIN_CYCLES  = 2 * WINDOW_DEPTH + 8;

  // codes the block does not define
  localparam logic [FUNC_W-1:0]    FUNC_SPARE  = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  in_item_t              in_data_i   = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  out_item_t             out_data_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;

  sliding_window_mode_filter #(
    .MAX_WINDOW(WINDOW_DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #2 clk_i = ~clk_i;

  // predicted block state
  logic [CODE_W-1:0]  window_codes [WINDOW_DEPTH];
  logic [3:0]         wr_ptr;
  logic [CODE_W-1:0]  mode_now;
  logic [WSIZE_W-1:0] win_size_cfg;
  logic [CODE_W-1:0]  fill_code_cfg;

  in_item_t  sample_q [$];
  out_item_t filter_results_q [$];
  out_item_t exp_res;
  int        fail_count = 0;
  int        send_gap   = 0;
  int        recv_hold  = 0;
  bit        quiet_mode = 1'b0;
  logic      in_taken;
  logic      out_taken;

  function automatic out_item_t filter_step(input in_item_t item);
    int unsigned span;
    int unsigned slot;
    int unsigned best_cnt;
    int unsigned hist [NUM_CODES];
    out_item_t   res;
    span = (win_size_cfg == 0) ? 1 :
           ((win_size_cfg > WINDOW_DEPTH) ? WINDOW_DEPTH : win_size_cfg);
    res.found = 1'b0;
    case (item.func)
      FUNC_PUSH: begin
        // pointer left past a shrunken window restarts at entry 0
        slot = (wr_ptr >= span) ? 0 : wr_ptr;
        window_codes[slot] = item.code;
        wr_ptr = 4'((slot + 1) % span);
        foreach (hist[c]) hist[c] = 0;
        for (int k = 0; k < span; k++) hist[window_codes[k]]++;
        // strict compare: ties keep the lowest entry
        best_cnt = 0;
        for (int k = 0; k < span; k++) begin
          if (hist[window_codes[k]] > best_cnt) begin
            best_cnt = hist[window_codes[k]];
            mode_now = window_codes[k];
          end
        end
      end
      FUNC_QUERY: begin
        for (int k = 0; k < span; k++) begin
          if (window_codes[k] == item.code) res.found = 1'b1;
        end
      end
      FUNC_REINIT: begin
        for (int k = 0; k < WINDOW_DEPTH; k++) window_codes[k] = fill_code_cfg;
        wr_ptr   = '0;
        mode_now = fill_code_cfg;
      end
      default: ;
    endcase
    res.mode_code = mode_now;
    return res;
  endfunction

  // monitor: predicts on accepted input, checks accepted results
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_taken  <= 1'b0;
      out_taken <= 1'b0;
      for (int k = 0; k < WINDOW_DEPTH; k++) window_codes[k] = '0;
      wr_ptr        = '0;
      mode_now      = '0;
      win_size_cfg  = WINDOW_SIZE_RST;
      fill_code_cfg = START_CODE_RST;
    end else begin
      in_taken  <= in_valid_i && !in_stall_o;
      out_taken <= out_valid_o && !out_stall_i;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == REG_WINDOW_SIZE) begin
          win_size_cfg = cfg_wdata_i;
        end else if (cfg_index_i == REG_START_CODE) begin
          fill_code_cfg = cfg_wdata_i[CODE_W-1:0];
        end
      end
      if (in_valid_i && !in_stall_o) filter_results_q.push_back(filter_step(in_data_i));
      if (out_valid_o && !out_stall_i) begin
        if (filter_results_q.size() == 0) begin
          $error("unexpected result transaction: mode_code %0d found %0d",
                 out_data_o.mode_code, out_data_o.found);
          fail_count++;
        end else begin
          exp_res = filter_results_q.pop_front();
          if (out_data_o.mode_code !== exp_res.mode_code) begin
            $error("mode_code: expected %0d, actual %0d", exp_res.mode_code,
                   out_data_o.mode_code);
            fail_count++;
          end
          if (out_data_o.found !== exp_res.found) begin
            $error("found: expected %0d, actual %0d", exp_res.found, out_data_o.found);
            fail_count++;
          end
        end
      end
    end
  end

  // driver: holds a stalled transaction, otherwise waits its gap and sends the next
  always @(negedge clk_i) begin
    if (rst_ni && !(in_valid_i && !in_taken)) begin
      if (send_gap != 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (sample_q.size() != 0) begin
        in_data_i  <= sample_q.pop_front();
        in_valid_i <= 1'b1;
        send_gap = quiet_mode ? 0 : $urandom_range(0, 4);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_taken) recv_hold = quiet_mode ? 0 : $urandom_range(0, 4);
      if (recv_hold != 0) begin
        recv_hold--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic add_sample(input logic [FUNC_W-1:0] func, input logic [CODE_W-1:0] code);
    in_item_t item;
    item.func = func;
    item.code = code;
    sample_q.push_back(item);
  endtask

  task automatic wait_drain();
    @(posedge clk_i);
    while (sample_q.size() != 0 || in_valid_i || filter_results_q.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // leaves cfg_valid_i high so back-to-back writes need no idle gap between them
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  task automatic end_writes();
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    int unsigned roll;
    int unsigned code_hi;
    logic [FUNC_W-1:0] func;
    logic [CFG_DATA_W-1:0] size_val;
    logic [CFG_DATA_W-1:0] start_val;

    // reset edge at time zero so registers are defined from the first clock
    rst_ni <= 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: size 8, start code 0
    add_sample(FUNC_QUERY, 3'd0);
    add_sample(FUNC_QUERY, 3'd7);
    add_sample(FUNC_PUSH, 3'd7);
    add_sample(FUNC_PUSH, 3'd7);
    add_sample(FUNC_PUSH, 3'd3);
    add_sample(FUNC_QUERY, 3'd3);
    add_sample(FUNC_SPARE, 3'd5);
    add_sample(FUNC_REINIT, 3'd0);
    add_sample(FUNC_QUERY, 3'd7);
    wait_drain();

    // full window, start code from masked data, writes to undefined indexes
    write_reg(REG_WINDOW_SIZE, 5'd16);
    write_reg(REG_START_CODE, 5'h1F);
    write_reg(REG_SPARE_2, 5'h0A);
    write_reg(REG_SPARE_3, 5'h15);
    end_writes();
    add_sample(FUNC_REINIT, 3'd2);
    for (int k = 0; k < 10; k++) add_sample(FUNC_PUSH, k[CODE_W-1:0]);
    wait_drain();

    // shrink below the pointer
    write_reg(REG_WINDOW_SIZE, 5'd3);
    end_writes();
    add_sample(FUNC_PUSH, 3'd1);
    add_sample(FUNC_PUSH, 3'd2);
    add_sample(FUNC_PUSH, 3'd2);
    add_sample(FUNC_QUERY, 3'd7);
    add_sample(FUNC_QUERY, 3'd1);
    wait_drain();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: size_val = 5'd0;
        1: size_val = 5'd31;
        2: size_val = 5'd1;
        3: size_val = 5'd16;
        4: size_val = 5'd17;
        5: size_val = 5'd2;
        default: size_val = CFG_DATA_W'($urandom_range(0, 31));
      endcase
      case (ph)
        0: start_val = 5'h18;
        1: start_val = 5'h07;
        default: start_val = CFG_DATA_W'($urandom_range(0, 31));
      endcase
      code_hi = (ph % 3 == 0) ? 1 : ((ph % 3 == 1) ? 7 : 3);
      quiet_mode = (ph % 3 == 2);

      write_reg(REG_WINDOW_SIZE, size_val);
      write_reg(REG_START_CODE, start_val);
      if (ph % 2 == 1) write_reg((ph % 4 == 1) ? REG_SPARE_2 : REG_SPARE_3,
                                 CFG_DATA_W'($urandom_range(0, 31)));
      end_writes();

      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // hold off mid-phase until every result is back
        if (i == PHASE_ITEMS / 2) wait_drain();
        roll = $urandom_range(0, 99);
        if (roll < 55) func = FUNC_PUSH;
        else if (roll < 85) func = FUNC_QUERY;
        else if (roll < 93) func = FUNC_REINIT;
        else func = FUNC_SPARE;
        add_sample(func, CODE_W'($urandom_range(0, code_hi)));
      end
      wait_drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && filter_results_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

### filelist.f
+incdir+src
src/swmf_pkg.sv
src/swmf_ram.sv
src/swmf_ctrl.sv
src/swmf_dpath.sv
src/sliding_window_mode_filter.sv
dv/sliding_window_mode_filter_tb.sv
